// ===== design/esmc_pkg.sv =====
`default_nettype none
package esmc_pkg;

	localparam int CNT_W  = 32;
	localparam int PROD_W = 42;
	localparam int DIV_CW = 6;

	localparam logic [2:0] CFG_FPS       = 3'd0;
	localparam logic [2:0] CFG_T_FAST    = 3'd1;
	localparam logic [2:0] CFG_T_SLOW    = 3'd2;
	localparam logic [2:0] CFG_FULL_CAP  = 3'd3;
	localparam logic [2:0] CFG_SPD_INT   = 3'd4;
	localparam logic [2:0] CFG_WARMUP    = 3'd5;
	localparam logic [2:0] CFG_INIT_MODE = 3'd6;

	localparam logic [2:0] RSN_NONE      = 3'd0;
	localparam logic [2:0] RSN_ROSE_CHK  = 3'd1;
	localparam logic [2:0] RSN_FELL_CHK  = 3'd2;
	localparam logic [2:0] RSN_ROSE_CHG  = 3'd3;
	localparam logic [2:0] RSN_FELL_CHG  = 3'd4;
	localparam logic [2:0] RSN_FULL      = 3'd5;
	localparam logic [2:0] RSN_IDLE_SLOW = 3'd6;

	localparam logic [3:0] MODE_MIN = 4'd1;
	localparam logic [3:0] MODE_MAX = 4'd6;

	localparam logic [31:0] MS_PER_S = 32'd1000;

	// ceil(2^38 / 1000): exact floor division by 1000 for any 32-bit value
	localparam logic [28:0] RCP_1000 = 29'd274877907;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RCP1,
		S_RCP2,
		S_RCP3,
		S_RCP4,
		S_BACKLOG,
		S_FAST,
		S_SLOW,
		S_SPEED,
		S_MUL2,
		S_DIV2_GO,
		S_DIV2_WAIT,
		S_DIV2_TAKE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic rcp1;
		logic rcp2;
		logic rcp3;
		logic rcp4;
		logic backlog;
		logic fast;
		logic slow;
		logic speed;
		logic mul2;
		logic div_go_spd;
		logic take_spd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic spd_need;
		logic out_free;
	} sts_t;

	function automatic logic beyond(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b,
			input logic [12:0] c);
		logic [CNT_W-1:0] d;
		d = a - b;
		return (a > b) && (d > {{(CNT_W-13){1'b0}}, c});
	endfunction

	function automatic logic [3:0] clamp_mode(input logic signed [5:0] m);
		logic [3:0] r;
		if (m < 6'sd1) begin
			r = MODE_MIN;
		end else if (m > 6'sd6) begin
			r = MODE_MAX;
		end else begin
			r = m[3:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/esmc_if.sv =====
`default_nettype none
interface esmc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [31:0] frames_done;
	modport source (output valid, output now_ms, output frames_done, input ready);
	modport sink (input valid, input now_ms, input frames_done, output ready);
endinterface

interface esmc_out_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  mode;
	logic signed [31:0] backlog;
	logic        [31:0] speed_milli;
	logic        [2:0]  reason;
	modport source (output valid, output mode, output backlog, output speed_milli,
		output reason, input ready);
	modport sink (input valid, input mode, input backlog, input speed_milli,
		input reason, output ready);
endinterface
`default_nettype wire

// ===== design/encoder_speed_mode_controller.sv =====
// Flow: each frame steps through the reciprocal, backlog, fast, slow, speed
// and finish states; a throughput measurement adds a bit-serial long division.
// Throughput: one frame at a time; the divider and a stalled output both
// hold the next frame off.
// Reset: arst_n clears all history and restores default register values.
`default_nettype none
module encoder_speed_mode_controller
	import esmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	esmc_in_if.sink          in_ch,
	esmc_out_if.source       out_ch,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [11:0] wr_data
);

	cmd_t        cmd;
	sts_t        sts;
	logic        in_ready;
	logic        o_valid;
	logic [3:0]  o_mode;
	logic [31:0] o_bl, o_spd;
	logic [2:0]  o_rsn;

	esmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	esmc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.in_now_ms      (in_ch.now_ms),
		.in_frames_done (in_ch.frames_done),
		.out_valid      (o_valid),
		.out_ready      (out_ch.ready),
		.out_mode       (o_mode),
		.out_backlog    (o_bl),
		.out_speed      (o_spd),
		.out_reason     (o_rsn)
	);

	assign in_ch.ready        = in_ready;
	assign out_ch.valid       = o_valid;
	assign out_ch.mode        = o_mode;
	assign out_ch.backlog     = o_bl;
	assign out_ch.speed_milli = o_spd;
	assign out_ch.reason      = o_rsn;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ready |=> !in_ready)
		else $error("input taken while a frame is in flight");
	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> o_rsn <= RSN_IDLE_SLOW)
		else $error("reason code out of range");
	a_no_result_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ready && !o_valid |=> !o_valid)
		else $error("result appeared too early");
`endif

endmodule
`default_nettype wire

// ===== design/esmc_div.sv =====
`default_nettype none
module esmc_div
	import esmc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [31:0]       divisor,
	output logic                   busy,
	output logic [PROD_W-1:0]      quotient
);

	logic [32:0]       rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [31:0]       dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic [32:0]       rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[31:0], quo_q[PROD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CW'(PROD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/esmc_dp.sv =====
`default_nettype none
module esmc_dp
	import esmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [11:0] wr_data,
	input  wire logic [31:0] in_now_ms,
	input  wire logic [31:0] in_frames_done,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       out_mode,
	output logic [31:0]      out_backlog,
	output logic [31:0]      out_speed,
	output logic [2:0]       out_reason
);

	logic [7:0]  fps_q;
	logic [11:0] t1_q, t2_q, cap_q, spd_int_q, warm_cfg_q;

	logic [CNT_W-1:0] frames_in_q, fast_frame_q, slow_frame_q, spd_frame_q, chg_frame_q;
	logic [31:0] first_time_q, spd_time_q, done_at_chk_q, speed_q;
	logic signed [31:0] bl_chk_q, bl_chg_q;
	logic signed [1:0]  last_delta_q;
	logic [2:0]  last_reason_q, cause_q;
	logic        start_pend_q;
	logic [3:0]  mode_q;

	logic [31:0] now_q, done_q, overall_q, inst_q, numer_q, denom_q;
	logic        warm_q, spd_need_q;
	logic [PROD_W-1:0] prod_q;
	logic signed [31:0] backlog_q;

	logic [22:0] q1000_q;
	logic [9:0]  r1000_q;
	logic [30:0] qfps_q;
	logic [17:0] rfps_q;
	logic [31:0] exp_q;

	logic              out_valid_q;
	logic [3:0]        o_mode_q;
	logic [31:0]       o_bl_q, o_spd_q;
	logic [2:0]        o_rsn_q;

	logic              div_busy;
	logic [PROD_W-1:0] quot;

	esmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go_spd),
		.dividend (prod_q),
		.divisor  (denom_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	logic [31:0] quot_sat;
	assign quot_sat = (quot[PROD_W-1:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];

	// expected = (overall / 1000) * fps + ((overall % 1000) * fps) / 1000
	logic [60:0] q_prod;
	logic [9:0]  q_lo_x1000;
	logic [46:0] y_prod;
	assign q_prod     = {29'd0, overall_q} * {32'd0, RCP_1000};
	assign q_lo_x1000 = q1000_q[9:0] * MS_PER_S[9:0];
	assign y_prod     = {29'd0, rfps_q} * {18'd0, RCP_1000};

	logic signed [33:0] bl_diff;
	logic signed [31:0] bl_sat;
	assign bl_diff = $signed({2'b00, exp_q}) - $signed({2'b00, frames_in_q});
	always_comb begin
		if (bl_diff < -34'sd2147483648) begin
			bl_sat = 32'sh8000_0000;
		end else if (bl_diff > 34'sd2147483647) begin
			bl_sat = 32'sh7FFF_FFFF;
		end else begin
			bl_sat = bl_diff[31:0];
		end
	end

	logic signed [33:0] bl, bchk, bchg, t1s, t3s, fps_s, fps3;
	logic [9:0]  fps_x3;
	logic [15:0] fps_r;
	logic [12:0] fps2, t2x2;
	assign fps_x3 = {2'b00, fps_q} + {1'b0, fps_q, 1'b0};
	assign fps_r  = {8'd0, fps_q} * 16'd171;
	assign fps2   = {4'd0, fps_q, 1'b0};
	assign t2x2   = {t2_q, 1'b0};
	assign bl     = {{2{backlog_q[31]}}, backlog_q};
	assign bchk   = {{2{bl_chk_q[31]}}, bl_chk_q};
	assign bchg   = {{2{bl_chg_q[31]}}, bl_chg_q};
	assign t1s    = {22'd0, t1_q};
	assign fps_s  = {26'd0, fps_q};
	assign fps3   = {27'd0, fps_r[15:9]};
	assign t3s    = ({24'd0, fps_x3} < {22'd0, cap_q}) ? {24'd0, fps_x3} : {22'd0, cap_q};

	logic f_run, f_dn, f_up, f_full, f_dn_chk, f_up_chk;
	logic signed [2:0] f_sum;
	logic signed [1:0] f_delta;
	logic [2:0] f_cause;
	always_comb begin
		f_run    = warm_q && beyond(frames_in_q, fast_frame_q, {1'b0, t1_q});
		f_dn_chk = bchk > bl + t1s;
		f_dn     = (bl < fps_s) && ((last_delta_q >= 2'sd0) ||
			beyond(frames_in_q, chg_frame_q, fps2)) &&
			(f_dn_chk || ((bchg > t1s + bl) && (bl < t1s)));
		f_up_chk = bl > t1s + bchk;
		f_up     = f_up_chk || (bl > t1s + bchg);
		f_full   = (bl > t3s) && ((last_reason_q != RSN_FULL) ||
			beyond(frames_in_q, chg_frame_q, t2x2)) && (bl > bchg);
		f_sum    = $signed({2'b00, f_up}) + $signed({2'b00, f_full}) - $signed({2'b00, f_dn});
		if (f_sum > 3'sd1) begin
			f_delta = 2'sd1;
		end else if (f_sum < -3'sd1) begin
			f_delta = -2'sd1;
		end else begin
			f_delta = f_sum[1:0];
		end
		if (f_full) begin
			f_cause = RSN_FULL;
		end else if (f_up) begin
			f_cause = f_up_chk ? RSN_ROSE_CHK : RSN_ROSE_CHG;
		end else if (f_dn) begin
			f_cause = f_dn_chk ? RSN_FELL_CHK : RSN_FELL_CHG;
		end else begin
			f_cause = RSN_NONE;
		end
	end

	logic s_run, s_dn;
	always_comb begin
		s_run = warm_q && beyond(frames_in_q, slow_frame_q, {1'b0, t2_q});
		s_dn  = beyond(frames_in_q, chg_frame_q, {1'b0, t2_q}) &&
			((last_reason_q != RSN_IDLE_SLOW) || beyond(frames_in_q, chg_frame_q, t2x2)) &&
			((bl - bchg < fps3) || (bl_chg_q == '0)) && (bl < t3s);
	end

	logic sp_take;
	assign sp_take = start_pend_q ||
		(warm_q && beyond(frames_in_q, spd_frame_q, {1'b0, spd_int_q}));

	logic first_frame;
	logic [31:0] first_eff;
	assign first_frame = frames_in_q == '0;
	assign first_eff   = first_frame ? in_now_ms : first_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q         <= 8'd30;
			t1_q          <= 12'd60;
			t2_q          <= 12'd180;
			cap_q         <= 12'd120;
			spd_int_q     <= 12'd60;
			warm_cfg_q    <= 12'd100;
			frames_in_q   <= '0;
			first_time_q  <= '0;
			spd_time_q    <= '0;
			done_at_chk_q <= '0;
			fast_frame_q  <= '0;
			slow_frame_q  <= '0;
			spd_frame_q   <= '0;
			chg_frame_q   <= '0;
			bl_chk_q      <= '0;
			bl_chg_q      <= '0;
			last_delta_q  <= '0;
			last_reason_q <= RSN_NONE;
			start_pend_q  <= 1'b0;
			mode_q        <= 4'd4;
			speed_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_FPS:       fps_q      <= wr_data[7:0];
					CFG_T_FAST:    t1_q       <= wr_data;
					CFG_T_SLOW:    t2_q       <= wr_data;
					CFG_FULL_CAP:  cap_q      <= wr_data;
					CFG_SPD_INT:   spd_int_q  <= wr_data;
					CFG_WARMUP:    warm_cfg_q <= wr_data;
					CFG_INIT_MODE: begin
						if (first_frame) begin
							mode_q <= wr_data[3:0];
						end
					end
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (first_frame) begin
					first_time_q <= in_now_ms;
				end else if (frames_in_q == {{(CNT_W-12){1'b0}}, warm_cfg_q}) begin
					start_pend_q <= 1'b1;
				end
			end
			if (cmd.fast && f_run) begin
				mode_q       <= clamp_mode($signed({2'b00, mode_q}) + 6'(f_delta));
				fast_frame_q <= frames_in_q;
				bl_chk_q     <= backlog_q;
				if (f_delta != 2'sd0) begin
					bl_chg_q     <= backlog_q;
					chg_frame_q  <= frames_in_q;
					last_delta_q <= f_delta;
				end
			end
			if (cmd.slow && s_run) begin
				mode_q       <= clamp_mode($signed({2'b00, mode_q}) - 6'(s_dn));
				slow_frame_q <= frames_in_q;
				if (s_dn) begin
					bl_chg_q     <= backlog_q;
					chg_frame_q  <= frames_in_q;
					last_delta_q <= -2'sd1;
				end
			end
			if (cmd.speed && sp_take) begin
				start_pend_q  <= 1'b0;
				spd_frame_q   <= frames_in_q;
				spd_time_q    <= now_q;
				done_at_chk_q <= done_q;
			end
			if (cmd.take_spd) begin
				speed_q <= quot_sat;
			end
			if (cmd.finish) begin
				if (cause_q != RSN_NONE) begin
					last_reason_q <= cause_q;
				end
				frames_in_q <= frames_in_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q     <= in_now_ms;
			done_q    <= in_frames_done;
			overall_q <= in_now_ms - first_eff;
			inst_q    <= in_now_ms - spd_time_q;
			warm_q    <= frames_in_q >= {{(CNT_W-12){1'b0}}, warm_cfg_q};
		end
		if (cmd.rcp1) begin
			q1000_q <= q_prod[60:38];
		end
		if (cmd.rcp2) begin
			r1000_q <= overall_q[9:0] - q_lo_x1000;
			qfps_q  <= {8'd0, q1000_q} * {23'd0, fps_q};
		end
		if (cmd.rcp3) begin
			rfps_q <= {8'd0, r1000_q} * {10'd0, fps_q};
		end
		if (cmd.rcp4) begin
			exp_q <= {1'b0, qfps_q} + {23'd0, y_prod[46:38]};
		end
		if (cmd.mul2) begin
			prod_q <= PROD_W'({10'd0, numer_q} * {32'd0, MS_PER_S[9:0]});
		end
		if (cmd.backlog) begin
			backlog_q <= bl_sat;
		end
		if (cmd.fast) begin
			cause_q <= f_run ? f_cause : RSN_NONE;
		end
		if (cmd.slow && s_run && s_dn) begin
			cause_q <= RSN_IDLE_SLOW;
		end
		if (cmd.speed) begin
			if (sp_take) begin
				if (start_pend_q) begin
					spd_need_q <= overall_q != '0;
					numer_q    <= done_q;
					denom_q    <= overall_q;
				end else begin
					spd_need_q <= inst_q != '0;
					numer_q    <= done_q - done_at_chk_q;
					denom_q    <= inst_q;
				end
			end else begin
				spd_need_q <= !warm_q && (overall_q != '0);
				numer_q    <= done_q;
				denom_q    <= overall_q;
			end
		end
		if (cmd.finish) begin
			o_mode_q <= mode_q;
			o_bl_q   <= backlog_q;
			o_spd_q  <= speed_q;
			o_rsn_q  <= (cause_q != RSN_NONE) ? cause_q : last_reason_q;
		end
	end

	always_comb begin
		sts.div_busy = div_busy;
		sts.spd_need = spd_need_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_mode    = o_mode_q;
	assign out_backlog = o_bl_q;
	assign out_speed   = o_spd_q;
	assign out_reason  = o_rsn_q;

endmodule
`default_nettype wire

// ===== design/esmc_ctrl.sv =====
`default_nettype none
module esmc_ctrl
	import esmc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_RCP1;
			S_RCP1:      state_d = S_RCP2;
			S_RCP2:      state_d = S_RCP3;
			S_RCP3:      state_d = S_RCP4;
			S_RCP4:      state_d = S_BACKLOG;
			S_BACKLOG:   state_d = S_FAST;
			S_FAST:      state_d = S_SLOW;
			S_SLOW:      state_d = S_SPEED;
			S_SPEED:     state_d = S_MUL2;
			S_MUL2:      state_d = sts.spd_need ? S_DIV2_GO : S_FINISH;
			S_DIV2_GO:   state_d = S_DIV2_WAIT;
			S_DIV2_WAIT: if (!sts.div_busy) state_d = S_DIV2_TAKE;
			S_DIV2_TAKE: state_d = S_FINISH;
			S_FINISH:    if (sts.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_RCP1:      cmd.rcp1       = 1'b1;
			S_RCP2:      cmd.rcp2       = 1'b1;
			S_RCP3:      cmd.rcp3       = 1'b1;
			S_RCP4:      cmd.rcp4       = 1'b1;
			S_BACKLOG:   cmd.backlog    = 1'b1;
			S_FAST:      cmd.fast       = 1'b1;
			S_SLOW:      cmd.slow       = 1'b1;
			S_SPEED:     cmd.speed      = 1'b1;
			S_MUL2:      cmd.mul2       = sts.spd_need;
			S_DIV2_GO:   cmd.div_go_spd = 1'b1;
			S_DIV2_TAKE: cmd.take_spd   = 1'b1;
			S_FINISH:    cmd.finish     = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire
